// ----- sv/caiu_pkg.sv -----
package caiu_pkg;

   // angle resolution: one full turn is 2**ANGLE_BITS units
   localparam int ANGLE_BITS = 16;
   localparam int LEN_BITS   = ANGLE_BITS + 1;
   localparam int TOL_BITS   = 8;

   typedef logic [ANGLE_BITS-1:0] angle_type;
   typedef logic [LEN_BITS-1:0]   length_type;
   typedef logic [2:0]            action_type;

   localparam length_type FULL_TURN = length_type'(1) << ANGLE_BITS;
   localparam length_type HALF_TURN = length_type'(1) << (ANGLE_BITS - 1);

   // action codes
   localparam action_type ACT_INTERSECT  = 3'd0;
   localparam action_type ACT_UNION      = 3'd1;
   localparam action_type ACT_POINT_IN_A = 3'd2;
   localparam action_type ACT_B_IN_A     = 3'd3;
   localparam action_type ACT_OVERLAP    = 3'd4;
   localparam action_type ACT_CLAMP      = 3'd5;
   localparam action_type ACT_COMPLEMENT = 3'd6;

   typedef struct packed {
      action_type action;
      angle_type  arc_a_start;
      length_type arc_a_length;
      logic       arc_a_empty;
      angle_type  arc_b_start;
      length_type arc_b_length;
      logic       arc_b_empty;
      angle_type  point;
   } req_type;

   typedef struct packed {
      angle_type  result_start;
      length_type result_length;
      logic       result_empty;
      logic       result_flag;
      angle_type  clamped_point;
   } rsp_type;

   // normalised arc
   typedef struct packed {
      angle_type  s;
      length_type l;
      logic       e;
   } arc_type;

endpackage

// ----- sv/circular_arc_interval_unit.sv -----
// channel   direction  handshake           payload
// req_      in         req_valid/req_stall  req_data (req_type)
// rsp_      out        rsp_valid/rsp_stall  rsp_data (rsp_type)
// csr_      in         csr_write_enable     csr_write_data (tolerance)
//
// one request a cycle while req_stall is low; a taken request passes through the
// request register, then the result register, with the arc logic between them.
// reset is synchronous: both valid flags clear, tolerance returns to 1.
// a stalled result holds in the result register while the request register
// still fills; req_stall rises only when both stages are occupied and stalled.
module circular_arc_interval_unit
   import caiu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_write_enable,
   input  logic [TOL_BITS-1:0] csr_write_data
);

   localparam int WIDE_BITS = ANGLE_BITS + 2;

   logic [TOL_BITS-1:0] tol_ff;
   logic                req_valid_ff;
   req_type             req_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic                rsp_free;
   logic                req_free;

   arc_type   arc_a;
   arc_type   arc_b;
   logic      a_full;
   logic      b_full;
   logic      bs_in_a;
   logic      as_in_b;
   angle_type d_ba;
   angle_type d_ab;
   angle_type end_a;
   angle_type end_b;
   angle_type d12;
   angle_type d21;
   length_type len_x;
   length_type len_y;
   logic [WIDE_BITS-1:0] uni_x;
   logic [WIDE_BITS-1:0] uni_y;
   logic [WIDE_BITS-1:0] lim;
   logic      contains;
   angle_type clamp_res;

   // saturate length and clear an empty arc
   function automatic arc_type make_arc(angle_type s, length_type l, logic e);
      arc_type r;
      r.e = e;
      r.s = e ? '0 : s;
      r.l = e ? '0 : ((l > FULL_TURN) ? FULL_TURN : l);
      return r;
   endfunction

   function automatic logic has_point(arc_type x, angle_type p);
      angle_type d;
      d = p - x.s;
      return !x.e && ({1'b0, d} <= x.l);
   endfunction

   function automatic length_type sat_wide(logic [WIDE_BITS-1:0] v);
      return (v > WIDE_BITS'(FULL_TURN)) ? FULL_TURN : v[LEN_BITS-1:0];
   endfunction

   // pipeline flow
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_free  = !req_valid_ff || rsp_free;
   assign req_stall = !req_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_BITS'(1);
      end else if (csr_write_enable) begin
         tol_ff <= csr_write_data;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_free) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_free && req_valid) begin
         req_ff <= req_data;
      end
   end

   // shared arc terms
   always_comb begin
      arc_a   = make_arc(req_ff.arc_a_start, req_ff.arc_a_length, req_ff.arc_a_empty);
      arc_b   = make_arc(req_ff.arc_b_start, req_ff.arc_b_length, req_ff.arc_b_empty);
      a_full  = !arc_a.e && (arc_a.l == FULL_TURN);
      b_full  = !arc_b.e && (arc_b.l == FULL_TURN);
      d_ba    = arc_b.s - arc_a.s;
      d_ab    = arc_a.s - arc_b.s;
      end_a   = arc_a.s + arc_a.l[ANGLE_BITS-1:0];
      end_b   = arc_b.s + arc_b.l[ANGLE_BITS-1:0];
      bs_in_a = has_point(arc_a, arc_b.s);
      as_in_b = has_point(arc_b, arc_a.s);
      d12     = end_a - arc_b.s;
      d21     = end_b - arc_a.s;
      // intersection lengths, valid only when the start lies inside
      len_x   = arc_a.l - {1'b0, d_ba};
      len_y   = arc_b.l - {1'b0, d_ab};
      // union lengths
      uni_x   = WIDE_BITS'(arc_b.l) + WIDE_BITS'(d_ba);
      uni_y   = WIDE_BITS'(arc_a.l) + WIDE_BITS'(d_ab);
      lim     = WIDE_BITS'(arc_a.l) + WIDE_BITS'(tol_ff);
   end

   // containment of b in a
   always_comb begin
      if (arc_b.e || a_full) begin
         contains = 1'b1;
      end else if (arc_a.e || (arc_b.l > arc_a.l)) begin
         contains = 1'b0;
      end else if ((arc_b.l == HALF_TURN) && (arc_a.l == HALF_TURN)) begin
         contains = (arc_a.s == arc_b.s);
      end else begin
         contains = (WIDE_BITS'(d_ba) <= lim) &&
                    (WIDE_BITS'(angle_type'(end_b - arc_a.s)) <= lim);
      end
   end

   // clamp point to a, ties go to the end
   always_comb begin
      if (has_point(arc_a, req_ff.point) || arc_a.e) begin
         clamp_res = req_ff.point;
      end else if (angle_type'(arc_a.s - req_ff.point) <
                   angle_type'(req_ff.point - end_a)) begin
         clamp_res = arc_a.s;
      end else begin
         clamp_res = end_a;
      end
   end

   // result selection
   always_comb begin
      arc_type r;
      r      = '0;
      rsp_in = '0;
      case (req_ff.action)
         ACT_INTERSECT: begin
            if (arc_a.e || arc_b.e) begin
               r = make_arc('0, '0, 1'b1);
            end else if (a_full) begin
               r = arc_b;
            end else if (b_full) begin
               r = arc_a;
            end else if (bs_in_a) begin
               r = make_arc(arc_b.s, (arc_b.l < len_x) ? arc_b.l : len_x, 1'b0);
            end else if (as_in_b) begin
               r = make_arc(arc_a.s, (arc_a.l < len_y) ? arc_a.l : len_y, 1'b0);
            end else begin
               r = make_arc('0, '0, 1'b1);
            end
         end
         ACT_UNION: begin
            if (arc_a.e) begin
               r = arc_b;
            end else if (arc_b.e) begin
               r = arc_a;
            end else if (bs_in_a) begin
               r = make_arc(arc_a.s, sat_wide((WIDE_BITS'(arc_a.l) > uni_x) ?
                                              WIDE_BITS'(arc_a.l) : uni_x), 1'b0);
            end else if (as_in_b) begin
               r = make_arc(arc_b.s, sat_wide((WIDE_BITS'(arc_b.l) > uni_y) ?
                                              WIDE_BITS'(arc_b.l) : uni_y), 1'b0);
            end else if (d12 < d21) begin
               r = make_arc(arc_b.s, {1'b0, d12}, 1'b0);
            end else begin
               r = make_arc(arc_a.s, {1'b0, d21}, 1'b0);
            end
         end
         ACT_POINT_IN_A: begin
            rsp_in.result_flag = has_point(arc_a, req_ff.point);
         end
         ACT_B_IN_A: begin
            rsp_in.result_flag = contains;
         end
         ACT_OVERLAP: begin
            rsp_in.result_flag = bs_in_a || as_in_b;
         end
         ACT_CLAMP: begin
            rsp_in.clamped_point = clamp_res;
         end
         ACT_COMPLEMENT: begin
            if (arc_a.e) begin
               r = make_arc(req_ff.arc_a_start, FULL_TURN, 1'b0);
            end else begin
               r = make_arc(end_a, FULL_TURN - arc_a.l, 1'b0);
            end
         end
         default: begin
            r = '0;
         end
      endcase
      rsp_in.result_start  = r.s;
      rsp_in.result_length = r.l;
      rsp_in.result_empty  = r.e;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- verif/tb_circular_arc_interval_unit.sv -----
`timescale 1ns / 1ps

module tb_circular_arc_interval_unit;
   import caiu_pkg::*;

   localparam int unsigned TURN       = 1 << ANGLE_BITS;
   localparam int unsigned HALF       = TURN >> 1;
   localparam int unsigned ANGLE_MASK = TURN - 1;
   localparam int          STALL_LIMIT = 2000;
   localparam action_type  ACT_UNDEFINED = 3'd7;

   typedef struct {
      int unsigned s;
      int unsigned l;
      bit          e;
   } arc_span;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write_enable = 1'b0;
   logic [TOL_BITS-1:0] csr_write_data = '0;

   req_type     pending_requests[$];
   rsp_type     expected_results[$];
   int unsigned tolerance_setting = 1;
   int          idle_pct = 22;
   int          requests_queued = 0;
   int          requests_accepted = 0;
   int          mismatches = 0;
   int          quiet_cycles = 0;
   logic        req_taken = 1'b0;

   circular_arc_interval_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial forever #4 clock = ~clock;

   // arc arithmetic for the prediction
   function automatic arc_span to_span(int unsigned s, int unsigned l, bit e);
      arc_span x;
      x.e = e;
      x.s = e ? 0 : (s & ANGLE_MASK);
      x.l = e ? 0 : ((l > TURN) ? TURN : l);
      return x;
   endfunction

   function automatic int unsigned ccw(int unsigned a, int unsigned b);
      return (a - b) & ANGLE_MASK;
   endfunction

   function automatic bit whole_circle(arc_span x);
      return !x.e && x.l >= TURN;
   endfunction

   function automatic int unsigned span_end(arc_span x);
      return (x.s + x.l) & ANGLE_MASK;
   endfunction

   function automatic bit covers_point(arc_span x, int unsigned p);
      return !x.e && ccw(p, x.s) <= x.l;
   endfunction

   // half-turn pair only fits when the starts agree
   function automatic bit covers_span(arc_span a, arc_span b);
      int unsigned lim;
      if (b.e || whole_circle(a)) return 1'b1;
      if (a.e || b.l > a.l) return 1'b0;
      if (b.l == HALF && a.l == HALF) return a.s == b.s;
      lim = a.l + tolerance_setting;
      return ccw(b.s, a.s) <= lim && ccw(span_end(b), a.s) <= lim;
   endfunction

   function automatic int unsigned min_of(int unsigned a, int unsigned b);
      return (a < b) ? a : b;
   endfunction

   function automatic int unsigned max_of(int unsigned a, int unsigned b);
      return (a > b) ? a : b;
   endfunction

   function automatic arc_span intersect_spans(arc_span a, arc_span b);
      if (a.e || b.e) return to_span(0, 0, 1'b1);
      if (whole_circle(a)) return b;
      if (whole_circle(b)) return a;
      if (covers_point(a, b.s))
         return to_span(b.s, min_of(b.l, a.l - ccw(b.s, a.s)), 1'b0);
      if (covers_point(b, a.s))
         return to_span(a.s, min_of(a.l, b.l - ccw(a.s, b.s)), 1'b0);
      return to_span(0, 0, 1'b1);
   endfunction

   // disjoint arcs: shorter covering arc, tie goes to the one starting at a
   function automatic arc_span unite_spans(arc_span a, arc_span b);
      int unsigned gap_ab, gap_ba;
      if (a.e) return b;
      if (b.e) return a;
      if (covers_point(a, b.s))
         return to_span(a.s, max_of(a.l, b.l + ccw(b.s, a.s)), 1'b0);
      if (covers_point(b, a.s))
         return to_span(b.s, max_of(b.l, a.l + ccw(a.s, b.s)), 1'b0);
      gap_ab = ccw(span_end(a), b.s);
      gap_ba = ccw(span_end(b), a.s);
      if (gap_ab < gap_ba) return to_span(b.s, gap_ab, 1'b0);
      return to_span(a.s, gap_ba, 1'b0);
   endfunction

   // equal distance goes to the end of the arc
   function automatic int unsigned clamp_into(arc_span a, int unsigned p);
      int unsigned tail;
      if (a.e || ccw(p, a.s) <= a.l) return p;
      tail = span_end(a);
      if (ccw(a.s, p) < ccw(p, tail)) return a.s;
      return tail;
   endfunction

   function automatic rsp_type predict_result(req_type q);
      arc_span a, b, r;
      rsp_type o;
      a = to_span(q.arc_a_start, q.arc_a_length, q.arc_a_empty);
      b = to_span(q.arc_b_start, q.arc_b_length, q.arc_b_empty);
      r = to_span(0, 0, 1'b0);
      o = '0;
      case (q.action)
         ACT_INTERSECT:  r = intersect_spans(a, b);
         ACT_UNION:      r = unite_spans(a, b);
         ACT_POINT_IN_A: o.result_flag = covers_point(a, q.point);
         ACT_B_IN_A:     o.result_flag = covers_span(a, b);
         ACT_OVERLAP:    o.result_flag = covers_point(a, b.s) || covers_point(b, a.s);
         ACT_CLAMP:      o.clamped_point = angle_type'(clamp_into(a, q.point));
         ACT_COMPLEMENT: begin
            if (a.e) r = to_span(q.arc_a_start, TURN, 1'b0);
            else r = to_span(span_end(a), TURN - a.l, 1'b0);
         end
         default: ;
      endcase
      o.result_start  = angle_type'(r.s);
      o.result_length = length_type'(r.l);
      o.result_empty  = r.e;
      return o;
   endfunction

   // request construction
   function automatic req_type build_request(action_type act, int unsigned as,
         int unsigned al, bit ae, int unsigned bs, int unsigned bl, bit be,
         int unsigned p);
      req_type q;
      q.action       = act;
      q.arc_a_start  = angle_type'(as);
      q.arc_a_length = length_type'(al);
      q.arc_a_empty  = ae;
      q.arc_b_start  = angle_type'(bs);
      q.arc_b_length = length_type'(bl);
      q.arc_b_empty  = be;
      q.point        = angle_type'(p);
      return q;
   endfunction

   task automatic push_request(req_type q);
      pending_requests.push_back(q);
      requests_queued++;
   endtask

   function automatic int unsigned jitter(int unsigned base);
      return (base + $urandom_range(8) - 4) & ANGLE_MASK;
   endfunction

   // lengths lean towards zero, half turn, full turn and oversized values
   function automatic length_type pick_length();
      int unsigned v;
      case ($urandom_range(9))
         0: v = 0;
         1: v = TURN;
         2: v = HALF;
         3: v = $urandom_range(16);
         4: v = TURN - $urandom_range(1, 16);
         5: v = TURN + $urandom_range(1, TURN - 1);
         6: v = HALF + $urandom_range(8) - 4;
         default: v = $urandom_range(TURN);
      endcase
      return length_type'(v);
   endfunction

   // b and the point mostly sit on or near the ends of a
   function automatic req_type random_request();
      req_type q;
      int unsigned a_len, a_end;
      q.action       = action_type'($urandom_range(7));
      q.arc_a_start  = angle_type'($urandom);
      q.arc_a_length = pick_length();
      q.arc_a_empty  = ($urandom_range(99) < 10);
      a_len = (q.arc_a_length > TURN) ? TURN : q.arc_a_length;
      a_end = (q.arc_a_start + a_len) & ANGLE_MASK;
      case ($urandom_range(6))
         0: q.arc_b_start = q.arc_a_start;
         1: q.arc_b_start = angle_type'(a_end);
         2: q.arc_b_start = angle_type'(jitter(q.arc_a_start));
         3: q.arc_b_start = angle_type'(jitter(a_end));
         4: q.arc_b_start = angle_type'(q.arc_a_start + $urandom_range(300));
         default: q.arc_b_start = angle_type'($urandom);
      endcase
      q.arc_b_length = pick_length();
      if (q.arc_a_length == HALF_TURN && $urandom_range(2) == 0)
         q.arc_b_length = HALF_TURN;
      q.arc_b_empty = ($urandom_range(99) < 10);
      case ($urandom_range(6))
         0: q.point = q.arc_a_start;
         1: q.point = angle_type'(a_end);
         2: q.point = angle_type'(jitter(q.arc_a_start));
         3: q.point = angle_type'(jitter(a_end));
         4: q.point = angle_type'(a_end + (TURN - a_len) / 2);
         default: q.point = angle_type'($urandom);
      endcase
      return q;
   endfunction

   task automatic run_random(int count);
      repeat (count) push_request(random_request());
   endtask

   // every accepted request answered and nothing waiting to be sent
   task automatic wait_drained();
      do @(negedge clock);
      while (requests_accepted != requests_queued || expected_results.size() != 0);
   endtask

   task automatic write_tolerance(logic [TOL_BITS-1:0] value);
      wait_drained();
      csr_write_data    <= value;
      csr_write_enable  <= 1'b1;
      tolerance_setting = 32'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= 50)
         $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // request driver and result stall, changed on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < idle_pct);
   end

   // monitor: check results, predict accepted requests, watch for a hang
   always @(posedge clock) begin
      rsp_type want;
      logic    req_fire, rsp_fire;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      req_taken <= req_fire;
      if (rsp_fire) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing pending", 64'(rsp_data), 64'(0));
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.result_start !== want.result_start)
               report_mismatch("result_start", 64'(rsp_data.result_start),
                               64'(want.result_start));
            if (rsp_data.result_length !== want.result_length)
               report_mismatch("result_length", 64'(rsp_data.result_length),
                               64'(want.result_length));
            if (rsp_data.result_empty !== want.result_empty)
               report_mismatch("result_empty", 64'(rsp_data.result_empty),
                               64'(want.result_empty));
            if (rsp_data.result_flag !== want.result_flag)
               report_mismatch("result_flag", 64'(rsp_data.result_flag),
                               64'(want.result_flag));
            if (rsp_data.clamped_point !== want.clamped_point)
               report_mismatch("clamped_point", 64'(rsp_data.clamped_point),
                               64'(want.clamped_point));
         end
      end
      if (req_fire) begin
         expected_results.push_back(predict_result(req_data));
         requests_accepted++;
      end
      if (reset || req_fire || rsp_fire) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("circular_arc_interval_unit test failed");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   // stimulus sequence
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners at the reset tolerance
      push_request(build_request(ACT_INTERSECT, 0, 0, 0, 0, 0, 0, 0));
      push_request(build_request(ACT_INTERSECT, 'h1234, 'h100, 1, 'h1200, 'h400, 0, 0));
      push_request(build_request(ACT_INTERSECT, 'h4000, TURN, 0, 'hF000, 'h3000, 0, 0));
      push_request(build_request(ACT_INTERSECT, 'h0100, 'h2000, 0, 'h9000, 'h1FFFF, 0, 0));
      // arcs that meet at both ends
      push_request(build_request(ACT_INTERSECT, 0, 'hC000, 0, 'h8000, 'hC000, 0, 0));
      push_request(build_request(ACT_INTERSECT, 0, 'h1000, 0, 'h8000, 'h1000, 0, 0));
      push_request(build_request(ACT_UNION, 'h5555, 'h10, 1, 'hAAAA, 'h20, 1, 0));
      push_request(build_request(ACT_UNION, 'h7000, 'h100, 1, 'hFFFF, 'h300, 0, 0));
      // disjoint union with equal gaps
      push_request(build_request(ACT_UNION, 0, 'h1000, 0, 'h8000, 'h1000, 0, 0));
      push_request(build_request(ACT_UNION, 'hF000, 'h2000, 0, 'h0800, 'h4000, 0, 0));
      push_request(build_request(ACT_POINT_IN_A, 'hFF00, 'h200, 0, 0, 0, 0, 'h0100));
      push_request(build_request(ACT_POINT_IN_A, 'hFF00, 'h200, 0, 0, 0, 0, 'h0101));
      push_request(build_request(ACT_POINT_IN_A, 'h0000, TURN, 1, 0, 0, 0, 'h0000));
      // half turns inside each other only with equal starts
      push_request(build_request(ACT_B_IN_A, 'h2000, HALF, 0, 'h2000, HALF, 0, 0));
      push_request(build_request(ACT_B_IN_A, 'h2000, HALF, 0, 'h2001, HALF, 0, 0));
      push_request(build_request(ACT_B_IN_A, 'h2000, 'h10, 1, 'h3000, 'h10, 1, 0));
      push_request(build_request(ACT_B_IN_A, 'h9000, TURN, 0, 'h1234, 'hFFFF, 0, 0));
      push_request(build_request(ACT_B_IN_A, 0, 100, 0, 1, 100, 0, 0));
      push_request(build_request(ACT_OVERLAP, 'hFFF0, 'h20, 0, 'h0010, 'h5, 0, 0));
      push_request(build_request(ACT_CLAMP, 'h1000, 'h100, 1, 0, 0, 0, 'h8000));
      // point exactly midway between the ends of the gap
      push_request(build_request(ACT_CLAMP, 0, HALF, 0, 0, 0, 0, 'hC000));
      push_request(build_request(ACT_CLAMP, 'h1000, 'h100, 0, 0, 0, 0, 'h1200));
      push_request(build_request(ACT_COMPLEMENT, 'h1234, 'h55, 1, 0, 0, 0, 0));
      push_request(build_request(ACT_COMPLEMENT, 'hABCD, 'h1FFFF, 0, 0, 0, 0, 0));
      push_request(build_request(ACT_COMPLEMENT, 'hFFF0, 'h20, 0, 0, 0, 0, 0));
      push_request(build_request(ACT_UNDEFINED, 'hFFFF, 'h1FFFF, 1, 'hFFFF, 'h1FFFF, 1,
                                 'hFFFF));

      // random phases across tolerance settings
      write_tolerance(8'h00);
      run_random(350);
      write_tolerance(8'hFF);
      run_random(350);
      write_tolerance(8'($urandom_range(2, 254)));
      idle_pct = 0;
      run_random(350);
      wait_drained();
      idle_pct = 22;
      write_tolerance(8'h01);
      run_random(400);
      write_tolerance(8'h80);
      run_random(350);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("circular_arc_interval_unit test passed");
      end else begin
         $display("circular_arc_interval_unit test failed");
      end
      $finish;
   end

endmodule
